>>> sv/cppm_pkg.sv
package cppm_pkg;

	localparam int TIMER_BITS = 16;
	localparam int EDGE_W     = 16;
	localparam int WIDTH_W    = 16;
	localparam int CFG_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam int SLOT_W     = 4;
	localparam int CHAN_W     = 3;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [CMP_W-1:0]      cmp_t;
	typedef logic [SLOT_W-1:0]     slot_t;
	typedef logic [CHAN_W-1:0]     chan_t;

	localparam logic [CFG_W-1:0] SYNC_RESET_TICKS = CFG_W'(3000);
	localparam slot_t SYNC_SLOT = SLOT_W'(0);
	localparam slot_t LAST_SLOT = SLOT_W'(8);
	localparam slot_t IDLE_SLOT = SLOT_W'(9);
	localparam slot_t LAST_PRIMARY_SLOT = SLOT_W'(4);

	// decoded result of one edge
	typedef struct packed {
		logic               emit;
		chan_t              channel_slot;
		logic [WIDTH_W-1:0] pulse_width;
		logic               primary_update;
	} slot_res_t;

	// slot 1..8 -> channel 3,1,2,4,5,6,7,8 (minus one)
	function automatic chan_t slot_to_channel(input slot_t slot);
		chan_t ch;
		case (slot)
			SLOT_W'(1): ch = CHAN_W'(2);
			SLOT_W'(2): ch = CHAN_W'(0);
			SLOT_W'(3): ch = CHAN_W'(1);
			SLOT_W'(4): ch = CHAN_W'(3);
			SLOT_W'(5): ch = CHAN_W'(4);
			SLOT_W'(6): ch = CHAN_W'(5);
			SLOT_W'(7): ch = CHAN_W'(6);
			SLOT_W'(8): ch = CHAN_W'(7);
			default:    ch = CHAN_W'(0);
		endcase
		return ch;
	endfunction

endpackage

>>> sv/cppm_frame_decoder.sv
// CPPM frame decoder: turns timestamped edges of a combined PPM stream into
// per-channel pulse widths.
// Edge channel: edge_valid / edge_stall carry edge_time, a sample of a
// free-running 16-bit timer. A request is taken on a clock edge with
// edge_valid high and edge_stall low.
// Result channel: result_valid / result_stall carry channel_slot,
// pulse_width and primary_update. Edges 1..8 after a sync gap each give one
// result (channels remapped 3,1,2,4,5,6,7,8); the sync edge and edges past
// the eighth give none.
// Config channel: cfg_valid / cfg_ready writes sync_gap_ticks (cfg_ready is
// always high). Write only while the block is idle.
// Path: a taken edge passes the input register, then the slot logic, then
// the result register, from which it is shown as a valid result.
// Throughput: one edge per clock while edge_stall is low; the gap subtract
// and threshold compare settle within a single stage.
// Reset (arst_n low): previous edge time 0, slot index 0, threshold 3000,
// both pipeline registers empty.
// Stall: while result_stall holds a pending result, an edge that would emit
// waits in the input register and edge_stall rises; edges that emit nothing
// still retire.
module cppm_frame_decoder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           edge_valid,
	output logic                           edge_stall,
	input  logic [cppm_pkg::EDGE_W-1:0]    edge_time,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [cppm_pkg::CFG_W-1:0]     cfg_data,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [cppm_pkg::CHAN_W-1:0]    channel_slot,
	output logic [cppm_pkg::WIDTH_W-1:0]   pulse_width,
	output logic                           primary_update
);
	import cppm_pkg::*;

	// input register
	logic              valid_s1;
	logic [EDGE_W-1:0] edge_time_s1;

	// threshold register
	logic [CFG_W-1:0]  sync_gap_q;

	slot_res_t res;
	logic      out_free;
	logic      advance;
	logic      accept;

	// the edge in s1 retires when it emits nothing or the result reg frees up
	assign advance    = valid_s1 && (!res.emit || out_free);
	assign edge_stall = valid_s1 && !advance;
	assign accept     = edge_valid && !edge_stall;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			edge_time_s1 <= edge_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_gap_q <= SYNC_RESET_TICKS;
		end else if (cfg_valid && cfg_ready) begin
			sync_gap_q <= cfg_data;
		end
	end

	cppm_slot_tracker u_slot (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.now      (timer_t'(edge_time_s1)),
		.sync_gap (sync_gap_q),
		.res      (res)
	);

	cppm_result_reg u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (advance),
		.res            (res),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.out_free       (out_free),
		.channel_slot   (channel_slot),
		.pulse_width    (pulse_width),
		.primary_update (primary_update)
	);

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		edge_stall |-> valid_s1 && result_valid && result_stall)
		else $error("input stalled without a blocked result");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted edge lost");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		edge_stall |=> valid_s1 && $stable(edge_time_s1))
		else $error("stalled edge changed");

endmodule

>>> sv/cppm_slot_tracker.sv
module cppm_slot_tracker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     advance,
	input  cppm_pkg::timer_t         now,
	input  logic [cppm_pkg::CFG_W-1:0] sync_gap,
	output cppm_pkg::slot_res_t      res
);
	import cppm_pkg::*;

	timer_t last_edge_q;
	slot_t  slot_q;
	timer_t gap;
	logic   is_sync;
	slot_t  slot_eff;
	slot_t  slot_nxt;

	always_comb begin
		gap      = now - last_edge_q;
		is_sync  = cmp_t'(gap) > cmp_t'(sync_gap);
		slot_eff = is_sync ? SYNC_SLOT : slot_q;

		if (slot_eff == SYNC_SLOT) begin
			slot_nxt = SLOT_W'(1);
		end else if (slot_eff > LAST_SLOT) begin
			slot_nxt = IDLE_SLOT;
		end else begin
			slot_nxt = slot_eff + SLOT_W'(1);
		end

		res.emit           = (slot_eff != SYNC_SLOT) && (slot_eff <= LAST_SLOT);
		res.channel_slot   = slot_to_channel(slot_eff);
		res.pulse_width    = WIDTH_W'(gap);
		res.primary_update = (slot_eff <= LAST_PRIMARY_SLOT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			slot_q      <= SYNC_SLOT;
		end else if (advance) begin
			last_edge_q <= now;
			slot_q      <= slot_nxt;
		end
	end

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= IDLE_SLOT)
		else $error("slot index out of range");

	a_sync_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_sync |=> slot_q == SLOT_W'(1))
		else $error("sync gap did not restart frame");

	a_primary_chan: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit && res.primary_update |-> res.channel_slot <= CHAN_W'(3))
		else $error("primary flag on secondary channel");

endmodule

>>> sv/cppm_result_reg.sv
module cppm_result_reg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  cppm_pkg::slot_res_t            res,
	input  logic                           result_stall,
	output logic                           result_valid,
	output logic                           out_free,
	output logic [cppm_pkg::CHAN_W-1:0]    channel_slot,
	output logic [cppm_pkg::WIDTH_W-1:0]   pulse_width,
	output logic                           primary_update
);
	import cppm_pkg::*;

	logic               valid_q;
	chan_t              chan_q;
	logic [WIDTH_W-1:0] width_q;
	logic               prim_q;
	logic               take;

	assign out_free = !valid_q || !result_stall;
	assign take     = load && res.emit && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			chan_q  <= res.channel_slot;
			width_q <= res.pulse_width;
			prim_q  <= res.primary_update;
		end
	end

	assign result_valid   = valid_q;
	assign channel_slot   = chan_q;
	assign pulse_width    = width_q;
	assign primary_update = prim_q;

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		load && res.emit |-> out_free)
		else $error("emitting request retired into a full result register");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && result_stall |=> valid_q && $stable(width_q) && $stable(chan_q))
		else $error("stalled result changed");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_q)
		else $error("loaded result not presented");

endmodule
